// File: hw/rtl/interval_gated_pitch_quantizer_core_defines.svh
// Assertion macros of the pitch quantizer RTL, used by igpq_step.
`ifndef INTERVAL_GATED_PITCH_QUANTIZER_CORE_DEFINES_SVH
`define INTERVAL_GATED_PITCH_QUANTIZER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge out of reset.
`define IGPQ_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("igpq: assertion failed");

// Expression must never be true out of reset.
`define IGPQ_ASSERT_NEVER(name, clk, rstn, expr) \
  name: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("igpq: forbidden condition");

`else

`define IGPQ_ASSERT(name, clk, rstn, prop)
`define IGPQ_ASSERT_NEVER(name, clk, rstn, expr)

`endif

`endif

// File: hw/rtl/igpq_pkg.sv
// Shared types and constants of the interval-gated pitch quantizer.
package igpq_pkg;

  // Width of the internal held note registers
  localparam int unsigned PitchWidth = 16;
  // Largest note magnitude in cents that the 15-bit output can carry
  localparam int NoteLimit = 16300;
  // Largest interval in semitones; larger register values act as this
  localparam int unsigned IntervalMax = 11;
  // Reset value of the pulse length register
  localparam logic [15:0] PulseLenReset = 16'd48;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CfgIntervalA = 2'd0,
    CfgIntervalB = 2'd1,
    CfgPulseLen  = 2'd2
  } cfg_idx_e;

  // Input request payload
  typedef struct packed {
    logic signed [14:0] pitch_in;
    logic               patched;
  } in_req_t;

  // Result payload
  typedef struct packed {
    logic signed [14:0] pitch_out;
    logic               trigger;
  } out_rsp_t;

  // Request after the input register, with its rounded note
  typedef struct packed {
    logic signed [PitchWidth-1:0] note;
    logic signed [14:0]           pitch;
    logic                         patched;
  } staged_t;

  // Configuration register contents
  typedef struct packed {
    logic [3:0]  interval_a;
    logic [3:0]  interval_b;
    logic [15:0] pulse_len;
  } cfg_t;

endpackage

// File: hw/rtl/igpq_quant.sv
// Input register stage: captures a request and its nearest-semitone note.
module igpq_quant (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  igpq_pkg::in_req_t  in_req_i,
  output logic               stg_valid_o,
  output igpq_pkg::staged_t  stg_o,
  input  logic               stg_ready_i
);
  import igpq_pkg::*;

  logic              vld_q, vld_d;
  staged_t           stg_q;
  logic              load;
  logic [16:0]       shifted;
  logic [28:0]       prod;
  logic [8:0]        quot;
  logic signed [9:0] semis;
  logic signed [16:0] semis_x, cents;
  logic signed [PitchWidth-1:0] note;

  // Round to the nearest 100 cents, ties down: floor((p + 49 + 20000) / 100) - 200.
  // The divide by 100 is a multiply by 5243 / 2^19, exact over 0..36432.
  always_comb begin
    shifted = 17'($signed({{2{in_req_i.pitch_in[14]}}, in_req_i.pitch_in}) + 17'sd20049);
    prod    = 29'(shifted[15:0]) * 29'd5243;
    quot    = prod[27:19];
    semis   = $signed({1'b0, quot}) - 10'sd200;
    semis_x = 17'(semis);
    cents   = (semis_x <<< 6) + (semis_x <<< 5) + (semis_x <<< 2);
    if (cents > 17'(NoteLimit)) begin
      note = PitchWidth'(NoteLimit);
    end else if (cents < -17'(NoteLimit)) begin
      note = -PitchWidth'(NoteLimit);
    end else begin
      note = PitchWidth'(cents);
    end
  end

  // Accept when the stage is empty or drains this cycle
  assign in_stall_o = vld_q && !stg_ready_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    vld_d = vld_q;
    if (load) begin
      vld_d = 1'b1;
    end else if (stg_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Hold the request payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      stg_q.note    <= note;
      stg_q.pitch   <= in_req_i.pitch_in;
      stg_q.patched <= in_req_i.patched;
    end
  end

  assign stg_valid_o = vld_q;
  assign stg_o       = stg_q;

endmodule

// File: hw/rtl/igpq_step.sv
// Note-change decision, held-note state, trigger pulse and result register.
`include "interval_gated_pitch_quantizer_core_defines.svh"

module igpq_step (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  igpq_pkg::cfg_t     cfg_i,
  input  logic               stg_valid_i,
  input  igpq_pkg::staged_t  stg_i,
  output logic               stg_ready_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output igpq_pkg::out_rsp_t out_rsp_o
);
  import igpq_pkg::*;

  logic signed [PitchWidth-1:0] last_note_q, last_note_d;
  logic signed [PitchWidth-1:0] held_q, held_d;
  logic                         sel_q, sel_d;
  logic [15:0]                  rem_q, rem_d;
  logic                         trig_lvl_q, trig_lvl_d;
  logic                         out_vld_q, out_vld_d;
  out_rsp_t                     out_q, out_d;

  logic              step_en;
  logic [3:0]        iv_raw;
  logic [3:0]        iv;
  logic [10:0]       thr;
  logic signed [16:0] diff;
  logic [16:0]       gap;
  logic              hit;
  logic [15:0]       rem_base;

  // Interval in semitones to cents
  function automatic logic [10:0] semis_to_cents(input logic [3:0] s);
    logic [10:0] c;
    c = (11'(s) << 6) + (11'(s) << 5) + (11'(s) << 2);
    return c;
  endfunction

  // Result register frees up when empty or taken this cycle
  assign stg_ready_o = !out_vld_q || !out_stall_i;
  assign step_en     = stg_valid_i && stg_ready_o;

  // Distance to the last note against the active interval
  always_comb begin
    iv_raw = sel_q ? cfg_i.interval_b : cfg_i.interval_a;
    iv     = (iv_raw > 4'(IntervalMax)) ? 4'(IntervalMax) : iv_raw;
    thr    = semis_to_cents(iv);
    diff   = 17'(stg_i.pitch) - 17'(last_note_q);
    gap    = diff[16] ? 17'(-diff) : 17'(diff);
    hit    = stg_i.patched && (gap >= 17'(thr));
  end

  // Update held note, interval select and pulse counter
  always_comb begin
    last_note_d = last_note_q;
    held_d      = held_q;
    sel_d       = sel_q;
    rem_d       = rem_q;
    trig_lvl_d  = trig_lvl_q;
    rem_base    = rem_q;
    out_d       = out_q;
    if (hit && (cfg_i.pulse_len > rem_q)) begin
      rem_base = cfg_i.pulse_len;
    end
    if (stg_i.patched) begin
      if (hit) begin
        last_note_d = stg_i.note;
        held_d      = stg_i.note;
        sel_d       = ~sel_q;
      end
      if (rem_base != 16'd0) begin
        rem_d      = rem_base - 16'd1;
        trig_lvl_d = 1'b1;
      end else begin
        trig_lvl_d = 1'b0;
      end
    end else begin
      held_d = '0;
    end
    out_d.pitch_out = held_d[14:0];
    out_d.trigger   = trig_lvl_d;
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (stg_ready_o) begin
      out_vld_d = stg_valid_i;
    end
  end

  // Advance state on each consumed request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_note_q <= '0;
      held_q      <= '0;
      sel_q       <= 1'b0;
      rem_q       <= '0;
      trig_lvl_q  <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      if (step_en) begin
        last_note_q <= last_note_d;
        held_q      <= held_d;
        sel_q       <= sel_d;
        rem_q       <= rem_d;
        trig_lvl_q  <= trig_lvl_d;
      end
    end
  end

  // Hold the result payload
  always_ff @(posedge clk_i) begin
    if (step_en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_rsp_o   = out_q;

  `IGPQ_ASSERT(a_note_in_range, clk_i, rst_ni, (last_note_q <= PitchWidth'(NoteLimit)) && (last_note_q >= -PitchWidth'(NoteLimit)))
  `IGPQ_ASSERT(a_unpatched_zero, clk_i, rst_ni, step_en && !stg_i.patched |=> out_q.pitch_out == '0)
  `IGPQ_ASSERT(a_sel_toggles_on_hit, clk_i, rst_ni, step_en |=> sel_q == ($past(sel_q) ^ $past(hit)))
  `IGPQ_ASSERT(a_hit_triggers, clk_i, rst_ni, step_en && hit && (cfg_i.pulse_len != 16'd0) |=> trig_lvl_q && out_q.trigger)
  `IGPQ_ASSERT_NEVER(a_idle_moves_state, clk_i, rst_ni, !$past(step_en) && !$stable(sel_q))

endmodule

// File: hw/rtl/interval_gated_pitch_quantizer_core.sv
// Top level of the interval-gated semitone pitch quantizer.
// Each accepted request (pitch in cents, 1200 per volt, and a patched flag)
// yields one result: the held pitch rounded to the nearest semitone (ties
// down, saturated to +-16300 cents, 0 while unpatched) and the trigger level.
// A new request is accepted every cycle while the result side does not
// stall; it is held first in the input register (which also does the
// rounding) and then passes the decision stage that updates the held
// note, the alternating interval select and the pulse counter before
// loading the result register.
// Registers: index 0 first interval, 1 second interval (both in semitones,
// 12..15 act as 11), 2 trigger pulse length in ticks; write them while idle.
module interval_gated_pitch_quantizer_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  igpq_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output igpq_pkg::out_rsp_t out_rsp_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i
);
  import igpq_pkg::*;

  cfg_t    cfg_q, cfg_d;
  logic    stg_valid;
  staged_t stg;
  logic    stg_ready;

  // Decode configuration writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgIntervalA: cfg_d.interval_a = cfg_wdata_i[3:0];
        CfgIntervalB: cfg_d.interval_b = cfg_wdata_i[3:0];
        CfgPulseLen:  cfg_d.pulse_len  = cfg_wdata_i;
        default:      cfg_d            = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.interval_a <= '0;
      cfg_q.interval_b <= '0;
      cfg_q.pulse_len  <= PulseLenReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  igpq_quant u_quant (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .stg_valid_o (stg_valid),
    .stg_o       (stg),
    .stg_ready_i (stg_ready)
  );

  igpq_step u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .stg_valid_i (stg_valid),
    .stg_i       (stg),
    .stg_ready_o (stg_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

// File: bench/interval_gated_pitch_quantizer_core_tb.sv
// Self-checking testbench of the interval-gated semitone pitch quantizer core.
module interval_gated_pitch_quantizer_core_tb;
  import igpq_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int PhaseItems = 100;
  localparam int IdlePct    = 22;
  localparam int ReportMax  = 10;

  // Track held note, interval alternation and pulse; queue expected results
  class pitch_scoreboard;
    logic [3:0]                   interval_a;
    logic [3:0]                   interval_b;
    logic [15:0]                  pulse_len;
    logic signed [PitchWidth-1:0] last_note;
    logic signed [PitchWidth-1:0] held_pitch;
    bit                           use_b;
    logic [15:0]                  pulse_left;
    bit                           trig_level;
    out_rsp_t                     expected_q[$];
    int                           mismatches;

    function new();
      interval_a = '0;
      interval_b = '0;
      pulse_len  = PulseLenReset;
      last_note  = '0;
      held_pitch = '0;
      use_b      = 1'b0;
      pulse_left = '0;
      trig_level = 1'b0;
      mismatches = 0;
    endfunction

    function void set_cfg(cfg_idx_e idx, logic [15:0] val);
      case (idx)
        CfgIntervalA: interval_a = val[3:0];
        CfgIntervalB: interval_b = val[3:0];
        CfgPulseLen:  pulse_len  = val;
        default: ;
      endcase
    endfunction

    // Predict the result of one accepted request
    function void note_req(in_req_t req);
      int unsigned iv;
      int          pitch;
      int          gap;
      int          note;
      out_rsp_t    rsp;
      pitch = $signed(req.pitch_in);
      if (req.patched) begin
        iv = use_b ? interval_b : interval_a;
        if (iv > IntervalMax) iv = IntervalMax;
        gap = pitch - int'(last_note);
        if (gap < 0) gap = -gap;
        if (gap >= int'(iv * 100)) begin
          // round to nearest semitone, ties down, then saturate
          note = ((pitch + 20049) / 100 - 200) * 100;
          if (note > NoteLimit) note = NoteLimit;
          if (note < -NoteLimit) note = -NoteLimit;
          held_pitch = PitchWidth'(note);
          last_note  = PitchWidth'(note);
          use_b      = ~use_b;
          if (pulse_len > pulse_left) pulse_left = pulse_len;
        end
        if (pulse_left != 0) begin
          pulse_left = pulse_left - 1'b1;
          trig_level = 1'b1;
        end else begin
          trig_level = 1'b0;
        end
      end else begin
        held_pitch = '0;
      end
      rsp.pitch_out = held_pitch[14:0];
      rsp.trigger   = trig_level;
      expected_q.push_back(rsp);
    endfunction

    // Compare one accepted result with the oldest expectation
    function void check_rsp(out_rsp_t got);
      out_rsp_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportMax)
          $display("unexpected result: pitch_out=%0d trigger=%0b", got.pitch_out, got.trigger);
        return;
      end
      want = expected_q.pop_front();
      if (got.pitch_out !== want.pitch_out || got.trigger !== want.trigger) begin
        mismatches++;
        if (mismatches <= ReportMax)
          $display("result mismatch: pitch_out exp %0d got %0d, trigger exp %0b got %0b",
                   want.pitch_out, got.pitch_out, want.trigger, got.trigger);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function int failures();
      return mismatches + expected_q.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  in_req_t     in_req_i    = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_rsp_t    out_rsp_o;
  logic        cfg_we_i    = 1'b0;
  logic [1:0]  cfg_idx_i   = '0;
  logic [15:0] cfg_wdata_i = '0;

  pitch_scoreboard sb = new();
  bit              steady = 1'b0;
  int              cycles = 0;

  interval_gated_pitch_quantizer_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Stall the result side at random, except during the steady stretch
  always @(posedge clk_i) begin
    out_stall_i <= !steady && ($urandom_range(0, 99) < IdlePct);
  end

  // Check every accepted result
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_rsp(out_rsp_o);
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("[interval_gated_pitch_quantizer_core] ERROR");
      $finish;
    end
  end

  function automatic in_req_t mk_req(int pitch, bit patched);
    in_req_t req;
    req.pitch_in = pitch[14:0];
    req.patched  = patched;
    return req;
  endfunction

  // Mostly steps around the held note, some ties, some full-range jumps
  function automatic in_req_t rand_req();
    int roll;
    int pitch;
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      pitch = int'(sb.last_note) + $urandom_range(0, 2400) - 1200;
      if ($urandom_range(0, 4) == 0) pitch = (pitch / 100) * 100 + 50;
      if (pitch > 16383) pitch = 16383;
      if (pitch < -16384) pitch = -16384;
    end else begin
      pitch = $signed(15'($urandom()));
    end
    return mk_req(pitch, $urandom_range(0, 99) >= 15);
  endfunction

  // Send one request, idling first at random; hold it until taken
  task automatic send_req(in_req_t req);
    while (!steady && ($urandom_range(0, 99) < IdlePct)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_req(req);
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [15:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.set_cfg(idx, val);
  endtask

  // Drain the block, then load all three registers
  task automatic apply_setting(logic [3:0] ia, logic [3:0] ib, logic [15:0] plen);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    cfg_write(CfgIntervalA, 16'(ia));
    cfg_write(CfgIntervalB, 16'(ib));
    cfg_write(CfgPulseLen, plen);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(logic [3:0] ia, logic [3:0] ib, logic [15:0] plen, bit quiet);
    apply_setting(ia, ib, plen);
    steady = quiet;
    repeat (PhaseItems) send_req(rand_req());
    steady = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Defaults: interval zero, every patched tick requantizes
    send_req(mk_req(5, 1'b0));
    send_req(mk_req(0, 1'b1));
    send_req(mk_req(16383, 1'b1));
    send_req(mk_req(-16384, 1'b1));
    send_req(mk_req(150, 1'b1));
    send_req(mk_req(-150, 1'b1));
    send_req(mk_req(151, 1'b1));
    send_req(mk_req(-12000, 1'b1));
    send_req(mk_req(12000, 1'b1));
    send_req(mk_req(12000, 1'b0));

    // Widest interval, and register values above eleven
    apply_setting(4'd11, 4'd15, 16'd1);
    send_req(mk_req(10901, 1'b1));
    send_req(mk_req(10900, 1'b1));
    send_req(mk_req(9801, 1'b1));
    send_req(mk_req(9800, 1'b1));
    send_req(mk_req(9800, 1'b1));

    // Zero pulse length starts no pulse
    apply_setting(4'd0, 4'd0, 16'd0);
    send_req(mk_req(-3, 1'b1));
    send_req(mk_req(49, 1'b1));

    // A shorter pulse length must not cut a running pulse
    apply_setting(4'd0, 4'd0, 16'd30);
    send_req(mk_req(300, 1'b1));
    apply_setting(4'd0, 4'd0, 16'd5);
    send_req(mk_req(500, 1'b1));
    send_req(mk_req(-1, 1'b0));
    send_req(mk_req(-16384, 1'b0));
    send_req(mk_req(16383, 1'b0));

    // Random phases; the longest pulse goes last since it never runs out
    run_phase(4'd2, 4'd7, 16'd20, 1'b0);
    run_phase(4'd0, 4'd0, 16'd1, 1'b1);
    run_phase(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
              16'($urandom_range(0, 300)), 1'b0);
    run_phase(4'd5, 4'd12, 16'd0, 1'b0);
    run_phase(4'd11, 4'd15, 16'hFFFF, 1'b0);

    // Drain and watch for stray results
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.failures() == 0) begin
      $display("[interval_gated_pitch_quantizer_core] OK");
    end else begin
      $display("[interval_gated_pitch_quantizer_core] ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/igpq_pkg.sv
hw/rtl/igpq_quant.sv
hw/rtl/igpq_step.sv
hw/rtl/interval_gated_pitch_quantizer_core.sv
bench/interval_gated_pitch_quantizer_core_tb.sv
